// File: hw/rtl/wear_aware_free_block_pool_defines.svh
`ifndef WEAR_AWARE_FREE_BLOCK_POOL_DEFINES_SVH
`define WEAR_AWARE_FREE_BLOCK_POOL_DEFINES_SVH

// checked outside reset
`define WAFBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define WAFBP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/wafbp_pkg.sv
`default_nettype none
package wafbp_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1024;
  localparam int unsigned WEAR_WIDTH_DEF = 17;

  localparam int unsigned BLOCK_W    = 10;
  localparam int unsigned WEAR_OUT_W = 17;
  localparam int unsigned FREE_W     = 11;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned IN_DATA_W  = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd3000;
  localparam logic [THR_W-1:0]   THR_RST   = 11'd51;

  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GC_THRESHOLD = 1'b1;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_RETURN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

endpackage
`default_nettype wire

// File: hw/rtl/wafbp_ram.sv
`default_nettype none
module wafbp_ram #(
  parameter int unsigned DEPTH = wafbp_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned WIDTH = wafbp_pkg::BLOCK_W,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/wear_aware_free_block_pool.sv
// An allocate descends the heap level by level and a return climbs it; either walk may stop early on a compare.
//   An allocate from an empty pool, and a return that is retired or finds the pool full, answer without a walk.
// Throughput: one request at a time; the next is taken the cycle after the result registers.
// Reset: async, active low; then a clearing pass over all NUM_BLOCKS entries loads
//   the heap and zeroes the wear memory before the first request is taken.
`default_nettype none
module wear_aware_free_block_pool #(
  parameter int unsigned NUM_BLOCKS = wafbp_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned WEAR_WIDTH = wafbp_pkg::WEAR_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_tvalid_i,
  output logic                                      s_tready_o,
  input  wire logic [wafbp_pkg::IN_DATA_W-1:0]      s_tdata_i,  // block[9:0]
  input  wire logic                                 s_tuser_i,  // kind
  output logic                                      m_tvalid_o,
  input  wire logic                                 m_tready_i,
  // blk_id[9:0], wear_count[26:10], free_count[37:27], gc_needed[38]
  output logic      [wafbp_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic      [1:0]                           m_tuser_o,  // status
  input  wire logic                                 cfg_we_i,
  input  wire logic [wafbp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [wafbp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned WW = WEAR_WIDTH;
  localparam int unsigned BW = wafbp_pkg::BLOCK_W;
  localparam int unsigned OW = wafbp_pkg::WEAR_OUT_W;
  localparam int unsigned FW = wafbp_pkg::FREE_W;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ALLOC0 = 13'b0000000000100,
    S_ALLOC1 = 13'b0000000001000,
    S_ALLOC2 = 13'b0000000010000,
    S_DN0    = 13'b0000000100000,
    S_DN1    = 13'b0000001000000,
    S_DN2    = 13'b0000010000000,
    S_RET0   = 13'b0000100000000,
    S_RET1   = 13'b0001000000000,
    S_UP0    = 13'b0010000000000,
    S_UP1    = 13'b0100000000000,
    S_UP2    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_pend_q, out_pend_d;

  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] c_q, c_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          gc_q, gc_d;
  logic [wafbp_pkg::LIMIT_W-1:0] limit_q;
  logic [wafbp_pkg::THR_W-1:0]   thr_q;

  logic [AW-1:0] x_blk_q, x_blk_d;
  logic [WW-1:0] x_wear_q, x_wear_d;
  logic [AW-1:0] bl_q, bl_d, br_q, br_d;
  logic          rv_q, rv_d;
  logic [BW-1:0] blk_q, blk_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [BW-1:0] res_blk_q, res_blk_d;
  logic [OW-1:0] res_wear_q, res_wear_d;

  logic          out_valid_q;
  logic [wafbp_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [1:0]    out_user_q;

  logic          hs_we, ws_we;
  logic [AW-1:0] hs_waddr, hs_ra, hs_rb, ws_waddr, ws_ra, ws_rb;
  logic [AW-1:0] hs_wdata;
  logic [WW:0]   ws_wdata;
  logic [AW-1:0] hs_rda, hs_rdb;
  logic [WW:0]   ws_rda, ws_rdb;

  logic [AW+1:0] l_idx, r_idx, n_ext;
  logic [CW-1:0] n_dec;
  logic [WW-1:0] w_inc;
  logic          in_acc, out_load;
  logic [AW+BW-1:0] blk_ext;
  logic [BW+AW-1:0] sel_ext;
  logic [OW+WW-1:0] wear_ext_a, wear_ext_inc;
  logic [FW+CW-1:0] free_ext;
  logic [AW-1:0] m_idx, m_blk;
  logic [WW-1:0] m_wear;

  assign l_idx   = {1'b0, c_q, 1'b1};
  assign r_idx   = l_idx + (AW+2)'(1);
  assign n_ext   = (AW+2)'(n_q);
  assign n_dec   = n_q - CW'(1);
  assign blk_ext = {{AW{1'b0}}, blk_q};
  assign sel_ext = {{BW{1'b0}}, hs_rda};
  assign wear_ext_a   = {{OW{1'b0}}, ws_rda[WW-1:0]};
  assign w_inc   = (ws_rda[WW-1:0] == {WW{1'b1}}) ? ws_rda[WW-1:0]
                                                  : ws_rda[WW-1:0] + WW'(1);
  assign wear_ext_inc = {{OW{1'b0}}, w_inc};
  assign free_ext = {{FW{1'b0}}, n_q};
  assign in_acc   = s_tvalid_i && s_tready_o;
  assign out_load = out_pend_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = (state_q == S_IDLE) && !out_pend_q;

  assign m_idx  = (rv_q && ws_rdb[WW-1:0] < ws_rda[WW-1:0]) ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign m_blk  = (rv_q && ws_rdb[WW-1:0] < ws_rda[WW-1:0]) ? br_q : bl_q;
  assign m_wear = (rv_q && ws_rdb[WW-1:0] < ws_rda[WW-1:0]) ? ws_rdb[WW-1:0]
                                                            : ws_rda[WW-1:0];

  always_comb begin
    state_d    = state_q;
    out_pend_d = out_pend_q && !out_load;
    n_d = n_q;  c_d = c_q;  clr_d = clr_q;  gc_d = gc_q;
    x_blk_d = x_blk_q;  x_wear_d = x_wear_q;
    bl_d = bl_q;  br_d = br_q;  rv_d = rv_q;  blk_d = blk_q;
    res_st_d = res_st_q;  res_blk_d = res_blk_q;  res_wear_d = res_wear_q;
    hs_we = 1'b0;  hs_waddr = c_q;  hs_wdata = x_blk_q;
    hs_ra = '0;  hs_rb = '0;
    ws_we = 1'b0;  ws_waddr = blk_ext[AW-1:0];  ws_wdata = '0;
    ws_ra = '0;  ws_rb = '0;
    case (state_q)
      S_CLEAR: begin
        hs_we = 1'b1;  hs_waddr = clr_q;  hs_wdata = clr_q;
        ws_we = 1'b1;  ws_waddr = clr_q;  ws_wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          blk_d = s_tdata_i[BW-1:0];
          if (s_tuser_i == wafbp_pkg::KIND_ALLOC) begin
            if (n_q == '0) begin
              res_st_d = wafbp_pkg::ST_EMPTY;  res_blk_d = '0;  res_wear_d = '0;
              out_pend_d = 1'b1;
            end else begin
              state_d = S_ALLOC0;
            end
          end else if (32'(s_tdata_i[BW-1:0]) >= 32'(NUM_BLOCKS)) begin
            res_st_d = wafbp_pkg::ST_OK;  res_blk_d = s_tdata_i[BW-1:0];
            res_wear_d = '0;  out_pend_d = 1'b1;
          end else begin
            state_d = S_RET0;
          end
        end
      end
      S_ALLOC0: begin
        hs_ra = '0;  hs_rb = n_dec[AW-1:0];
        n_d = n_dec;
        if (32'(n_dec) <= 32'(thr_q)) begin
          gc_d = 1'b1;
        end
        state_d = S_ALLOC1;
      end
      S_ALLOC1: begin
        ws_ra = hs_rda;  ws_rb = hs_rdb;
        res_blk_d = sel_ext[BW-1:0];
        x_blk_d = hs_rdb;
        state_d = S_ALLOC2;
      end
      S_ALLOC2: begin
        res_st_d = wafbp_pkg::ST_OK;
        res_wear_d = wear_ext_a[OW-1:0];
        x_wear_d = ws_rdb[WW-1:0];
        c_d = '0;
        state_d = S_DN0;
      end
      S_DN0: begin
        if (l_idx >= n_ext) begin
          hs_we = 1'b1;
          out_pend_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          hs_ra = l_idx[AW-1:0];  hs_rb = r_idx[AW-1:0];
          rv_d = r_idx < n_ext;
          state_d = S_DN1;
        end
      end
      S_DN1: begin
        ws_ra = hs_rda;  ws_rb = hs_rdb;
        bl_d = hs_rda;  br_d = hs_rdb;
        state_d = S_DN2;
      end
      S_DN2: begin
        hs_we = 1'b1;
        if (m_wear < x_wear_q) begin
          hs_wdata = m_blk;
          c_d = m_idx;
          state_d = S_DN0;
        end else begin
          out_pend_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RET0: begin
        ws_ra = blk_ext[AW-1:0];
        state_d = S_RET1;
      end
      S_RET1: begin
        res_blk_d = blk_q;
        if (ws_rda[WW]) begin
          res_st_d = wafbp_pkg::ST_BAD;  res_wear_d = wear_ext_a[OW-1:0];
          out_pend_d = 1'b1;  state_d = S_IDLE;
        end else begin
          ws_we = 1'b1;
          ws_wdata = {(33'(w_inc) > 33'(limit_q)), w_inc};
          res_wear_d = wear_ext_inc[OW-1:0];
          if (33'(w_inc) > 33'(limit_q)) begin
            res_st_d = wafbp_pkg::ST_BAD;
            out_pend_d = 1'b1;  state_d = S_IDLE;
          end else begin
            res_st_d = wafbp_pkg::ST_OK;
            if (32'(n_q) < 32'(NUM_BLOCKS)) begin
              x_blk_d = blk_ext[AW-1:0];  x_wear_d = w_inc;
              c_d = n_q[AW-1:0];  n_d = n_q + CW'(1);
              state_d = S_UP0;
            end else begin
              out_pend_d = 1'b1;  state_d = S_IDLE;
            end
          end
        end
      end
      S_UP0: begin
        if (c_q == '0) begin
          hs_we = 1'b1;
          out_pend_d = 1'b1;  state_d = S_IDLE;
        end else begin
          hs_ra = (c_q - AW'(1)) >> 1;
          state_d = S_UP1;
        end
      end
      S_UP1: begin
        ws_ra = hs_rda;  bl_d = hs_rda;
        state_d = S_UP2;
      end
      S_UP2: begin
        hs_we = 1'b1;
        if (ws_rda[WW-1:0] > x_wear_q) begin
          hs_wdata = bl_q;
          c_d = (c_q - AW'(1)) >> 1;
          state_d = S_UP0;
        end else begin
          out_pend_d = 1'b1;  state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;  out_pend_q <= 1'b0;  out_valid_q <= 1'b0;
      n_q <= CW'(NUM_BLOCKS);  c_q <= '0;  clr_q <= '0;  gc_q <= 1'b0;
      limit_q <= wafbp_pkg::LIMIT_RST;  thr_q <= wafbp_pkg::THR_RST;
    end else begin
      state_q <= state_d;  out_pend_q <= out_pend_d;
      n_q <= n_d;  c_q <= c_d;  clr_q <= clr_d;  gc_q <= gc_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == wafbp_pkg::CFG_ERASE_LIMIT) begin
          limit_q <= cfg_data_i[wafbp_pkg::LIMIT_W-1:0];
        end else begin
          thr_q <= cfg_data_i[wafbp_pkg::THR_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_blk_q <= x_blk_d;  x_wear_q <= x_wear_d;
    bl_q <= bl_d;  br_q <= br_d;  rv_q <= rv_d;  blk_q <= blk_d;
    res_st_q <= res_st_d;  res_blk_q <= res_blk_d;  res_wear_q <= res_wear_d;
    if (out_load) begin
      out_user_q <= res_st_q;
      out_data_q <= {1'b0, gc_q, free_ext[FW-1:0], res_wear_q, res_blk_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  wafbp_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(AW), .AW(AW)) u_slot_ram (
    .clk_i, .we_i(hs_we), .waddr_i(hs_waddr), .wdata_i(hs_wdata),
    .raddr_a_i(hs_ra), .raddr_b_i(hs_rb), .rdata_a_o(hs_rda), .rdata_b_o(hs_rdb)
  );

  // wear count with retired flag on top
  wafbp_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(WW + 1), .AW(AW)) u_wear_ram (
    .clk_i, .we_i(ws_we), .waddr_i(ws_waddr), .wdata_i(ws_wdata),
    .raddr_a_i(ws_ra), .raddr_b_i(ws_rb), .rdata_a_o(ws_rda), .rdata_b_o(ws_rdb)
  );

endmodule
`default_nettype wire

// File: hw/rtl/wafbp_chk.sv
`default_nettype none
`include "wear_aware_free_block_pool_defines.svh"
module wafbp_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_tready_o,
  input wire logic                             m_tvalid_o,
  input wire logic                             m_tready_i,
  input wire logic [wafbp_pkg::OUT_DATA_W-1:0] m_tdata_o,
  input wire logic [1:0]                       m_tuser_o
);

  logic gc_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_seen_q <= 1'b0;
    end else if (m_tvalid_o && m_tready_i && m_tdata_o[38]) begin
      gc_seen_q <= 1'b1;
    end
  end

  `WAFBP_ASSERT(a_empty_free, m_tvalid_o && m_tuser_o == wafbp_pkg::ST_EMPTY |-> m_tdata_o[37:27] == '0, "empty status with nonzero free count")
  `WAFBP_ASSERT(a_gc_sticky, m_tvalid_o && gc_seen_q |-> m_tdata_o[38], "gc flag dropped")
  `WAFBP_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "stalled result changed")
  `WAFBP_ASSERT_RST(a_rst_idle, !rst_ni |-> !m_tvalid_o && !s_tready_o, "handshake active in reset")

endmodule

bind wear_aware_free_block_pool wafbp_chk u_chk (.*);
`default_nettype wire
